FILE: hw/rtl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and codes for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 2;
    localparam int WAIT_W   = 31;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // operation codes
    localparam logic [OP_W-1:0] OP_ARM    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the request word
        logic remove;   // remove the id, or pop the due head on a tick
        logic finish;   // insert on arm, then capture the result word
    } ctrl_cmd_t;

endpackage

FILE: hw/rtl/sdtq_in_if.sv
// ----------------------------------------------------------------------------
// sdtq_in_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface sdtq_in_if;
    logic                         valid;
    logic                         ready;
    logic [sdtq_pkg::OP_W-1:0]    operation;
    logic [sdtq_pkg::ID_W-1:0]    timer_id;
    logic [sdtq_pkg::TIME_W-1:0]  deadline_ms;
    logic [sdtq_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output operation, output timer_id,
                    output deadline_ms, output now_ms, input ready);
    modport sink   (input valid, input operation, input timer_id,
                    input deadline_ms, input now_ms, output ready);
endinterface

FILE: hw/rtl/sdtq_out_if.sv
// ----------------------------------------------------------------------------
// sdtq_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface sdtq_out_if;
    logic                          valid;
    logic                          ready;
    logic [sdtq_pkg::STATUS_W-1:0] status;
    logic                          expired;
    logic [sdtq_pkg::ID_W-1:0]     expired_id;
    logic                          any_pending;
    logic [sdtq_pkg::WAIT_W-1:0]   wait_ms;

    modport source (output valid, output status, output expired, output expired_id,
                    output any_pending, output wait_ms, input ready);
    modport sink   (input valid, input status, input expired, input expired_id,
                    input any_pending, input wait_ms, output ready);
endinterface

FILE: hw/rtl/sdtq_ctrl.sv
// ----------------------------------------------------------------------------
// sdtq_ctrl
// Request sequencer: capture, remove, then insert and report.
// ----------------------------------------------------------------------------
module sdtq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdtq_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_REMOVE, S_FINISH} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // commands and next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/sdtq_datapath.sv
// ----------------------------------------------------------------------------
// sdtq_datapath
// Sorted slot array with shift-down removal and shift-up insertion.
// ----------------------------------------------------------------------------
module sdtq_datapath
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sdtq_pkg::ctrl_cmd_t                cmd,
    input  logic [sdtq_pkg::OP_W-1:0]          operation,
    input  logic [sdtq_pkg::ID_W-1:0]          timer_id,
    input  logic [sdtq_pkg::TIME_W-1:0]        deadline_ms,
    input  logic [sdtq_pkg::TIME_W-1:0]        now_ms,
    output logic [sdtq_pkg::STATUS_W-1:0]      status,
    output logic                               expired,
    output logic [sdtq_pkg::ID_W-1:0]          expired_id,
    output logic                               any_pending,
    output logic [sdtq_pkg::WAIT_W-1:0]        wait_ms
);

    localparam int TW = (TIME_BITS < sdtq_pkg::TIME_W) ? TIME_BITS : sdtq_pkg::TIME_W;
    localparam int N  = NUM_TIMERS;

    // request word
    logic [sdtq_pkg::OP_W-1:0]     op_reg;
    logic [sdtq_pkg::ID_W-1:0]     id_reg;
    logic [TW-1:0]                 dl_reg;
    logic [TW-1:0]                 now_reg;
    logic [sdtq_pkg::STATUS_W-1:0] st_reg;
    logic                          exp_reg;
    logic [sdtq_pkg::ID_W-1:0]     exp_id_reg;

    // slot cells
    logic [sdtq_pkg::ID_W-1:0] slot_id_reg [N];
    logic [TW-1:0]             slot_dl_reg [N];
    logic [N-1:0]              slot_valid_reg;

    // result word
    logic [sdtq_pkg::STATUS_W-1:0] r_status_reg;
    logic                          r_exp_reg;
    logic [sdtq_pkg::ID_W-1:0]     r_exp_id_reg;
    logic                          r_pend_reg;
    logic [sdtq_pkg::WAIT_W-1:0]   r_wait_reg;

    logic [N-1:0] match;
    logic [N-1:0] rm_sel;
    logic         found;
    logic         pop;
    logic [N-1:0] later;
    logic         full;
    logic         do_ins;
    logic         head_pend;
    logic [TW-1:0] head_dl;
    logic [TW-1:0] diff;

    // removal select: the matching cell (or the due head on a tick) and everything above it
    always_comb
    begin
        for (int i = 0; i < N; i++)
            match[i] = slot_valid_reg[i] && (slot_id_reg[i] == id_reg);
        found = |match;
        pop   = (op_reg == sdtq_pkg::OP_TICK) && slot_valid_reg[0]
                && (slot_dl_reg[0] <= now_reg);
        rm_sel[0] = pop || match[0];
        for (int i = 1; i < N; i++)
            rm_sel[i] = rm_sel[i-1] || match[i];
        if (op_reg != sdtq_pkg::OP_ARM && op_reg != sdtq_pkg::OP_CANCEL && !pop)
            rm_sel = '0;
    end

    // insertion point: first free cell or first strictly later deadline
    always_comb
    begin
        for (int i = 0; i < N; i++)
            later[i] = !slot_valid_reg[i] || (slot_dl_reg[i] > dl_reg);
        full   = slot_valid_reg[N-1];
        do_ins = (op_reg == sdtq_pkg::OP_ARM) && !full;
    end

    // head after this step
    always_comb
    begin
        head_pend = slot_valid_reg[0] || do_ins;
        head_dl   = (do_ins && later[0]) ? dl_reg : slot_dl_reg[0];
        diff      = (head_dl > now_reg) ? (head_dl - now_reg) : '0;
    end

    // request, flags and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            id_reg  <= timer_id;
            dl_reg  <= deadline_ms[TW-1:0];
            now_reg <= now_ms[TW-1:0];
        end
        if (cmd.remove)
        begin
            st_reg     <= (op_reg == sdtq_pkg::OP_CANCEL && !found)
                          ? sdtq_pkg::ST_NOT_ARMED : sdtq_pkg::ST_DONE;
            exp_reg    <= pop;
            exp_id_reg <= pop ? slot_id_reg[0] : '0;
        end
        if (cmd.finish)
        begin
            r_status_reg <= (op_reg == sdtq_pkg::OP_ARM && full) ? sdtq_pkg::ST_FULL : st_reg;
            r_exp_reg    <= exp_reg;
            r_exp_id_reg <= exp_id_reg;
            r_pend_reg   <= head_pend;
            if (!head_pend)
                r_wait_reg <= sdtq_pkg::WAIT_MAX;
            else if (|diff[TW-1:sdtq_pkg::WAIT_W])
                r_wait_reg <= sdtq_pkg::WAIT_MAX;
            else
                r_wait_reg <= diff[sdtq_pkg::WAIT_W-1:0];
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (cmd.remove && rm_sel[i] && i < N-1)
            begin
                slot_id_reg[i] <= slot_id_reg[(i < N-1) ? i+1 : i];
                slot_dl_reg[i] <= slot_dl_reg[(i < N-1) ? i+1 : i];
            end
            else if (cmd.finish && do_ins)
            begin
                if (i > 0 && later[(i > 0) ? i-1 : 0])
                begin
                    slot_id_reg[i] <= slot_id_reg[(i > 0) ? i-1 : 0];
                    slot_dl_reg[i] <= slot_dl_reg[(i > 0) ? i-1 : 0];
                end
                else if (later[i])
                begin
                    slot_id_reg[i] <= id_reg;
                    slot_dl_reg[i] <= dl_reg;
                end
            end
        end
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= '0;
        else
        begin
            for (int i = 0; i < N; i++)
            begin
                if (cmd.remove && rm_sel[i])
                    slot_valid_reg[i] <= (i < N-1) ? slot_valid_reg[(i < N-1) ? i+1 : i]
                                                   : 1'b0;
                else if (cmd.finish && do_ins)
                begin
                    if (i > 0 && later[(i > 0) ? i-1 : 0])
                        slot_valid_reg[i] <= slot_valid_reg[(i > 0) ? i-1 : 0];
                    else if (later[i])
                        slot_valid_reg[i] <= 1'b1;
                end
            end
        end
    end

    assign status      = r_status_reg;
    assign expired     = r_exp_reg;
    assign expired_id  = r_exp_id_reg;
    assign any_pending = r_pend_reg;
    assign wait_ms     = r_wait_reg;

endmodule

FILE: hw/rtl/sorted_deadline_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Sorted table of armed timers with arm, cancel and tick requests.
// ----------------------------------------------------------------------------
// After a request is accepted, a remove step removes the id (or pops the
// due head on a tick) by shifting the cells above it down, and a finish
// step inserts an arm at its sorted place by shifting later cells up and
// loads the result word; it waits while an earlier result is not taken.
// A new request is taken only after both steps; the result register lets the
// next request start while a result waits. Equal deadlines keep arm order.
module sorted_deadline_timer_queue
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    sdtq_in_if.sink     in_ch,
    sdtq_out_if.source  out_ch
);

    sdtq_pkg::ctrl_cmd_t cmd;

    sdtq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    sdtq_datapath #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (in_ch.operation),
        .timer_id    (in_ch.timer_id),
        .deadline_ms (in_ch.deadline_ms),
        .now_ms      (in_ch.now_ms),
        .status      (out_ch.status),
        .expired     (out_ch.expired),
        .expired_id  (out_ch.expired_id),
        .any_pending (out_ch.any_pending),
        .wait_ms     (out_ch.wait_ms)
    );

endmodule

FILE: hw/rtl/sdtq_checker.sv
// ----------------------------------------------------------------------------
// sdtq_checker
// Port-level checks on the timer queue request and result channels.
// ----------------------------------------------------------------------------
module sdtq_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sdtq_pkg::STATUS_W-1:0] status,
    input logic                          expired,
    input logic [sdtq_pkg::ID_W-1:0]     expired_id,
    input logic                          any_pending,
    input logic [sdtq_pkg::WAIT_W-1:0]   wait_ms
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wait_ms) && $stable(status))
        else $error("result word changed while stalled");

    // one request in flight: no accept right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // no expiry reports a zero id
    a_expid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !expired |-> expired_id == '0)
        else $error("expired id set without expiry");

    // an empty table waits indefinitely
    a_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_pending |-> wait_ms == sdtq_pkg::WAIT_MAX)
        else $error("wait not saturated with nothing pending");

    // an expiry only comes with a done status
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expired |-> status == sdtq_pkg::ST_DONE)
        else $error("expiry with error status");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .expired     (out_ch.expired),
    .expired_id  (out_ch.expired_id),
    .any_pending (out_ch.any_pending),
    .wait_ms     (out_ch.wait_ms)
);

FILE: sim/tb_sdtq_chan_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sdtq_chan_if
// Testbench-side view of the request and result channels.
// ----------------------------------------------------------------------------
// The block's own interfaces carry the words; this file only holds the
// word records the bench uses to pass requests and results around.
package tb_sdtq_pkg;

    typedef struct packed {
        logic [sdtq_pkg::OP_W-1:0]   operation;
        logic [sdtq_pkg::ID_W-1:0]   timer_id;
        logic [sdtq_pkg::TIME_W-1:0] deadline_ms;
        logic [sdtq_pkg::TIME_W-1:0] now_ms;
    } req_word_t;

    typedef struct packed {
        logic [sdtq_pkg::STATUS_W-1:0] status;
        logic                          expired;
        logic [sdtq_pkg::ID_W-1:0]     expired_id;
        logic                          any_pending;
        logic [sdtq_pkg::WAIT_W-1:0]   wait_ms;
    } rsp_word_t;
endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
// Directed table of requests (empty table, full table, re-arm, cancel misses,
// ties, time extremes, unused opcode) then random traffic over a small id
// and time window so ticks fire often. Every result is checked against a
// sorted-list model of the timer table kept in the bench.
module tb_top;

    localparam int NT       = 16;
    localparam int N_RANDOM = 1925;
    localparam logic [sdtq_pkg::OP_W-1:0] OP_NOP = 2'd3;
    localparam logic [sdtq_pkg::TIME_W-1:0] T_MAX = {sdtq_pkg::TIME_W{1'b1}};

    logic clk;
    logic rst_n;

    sdtq_in_if  in_ch();
    sdtq_out_if out_ch();

    sorted_deadline_timer_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // timer table model: armed entries in fire order
    logic [sdtq_pkg::ID_W-1:0]   tbl_id[$];
    logic [sdtq_pkg::TIME_W-1:0] tbl_dl[$];

    tb_sdtq_pkg::rsp_word_t rsp_expected[$];
    int        err_count;
    bit        rx_hold;        // long hold-off on result side
    bit        stim_done;

    function automatic tb_sdtq_pkg::rsp_word_t timer_step(tb_sdtq_pkg::req_word_t w);
        tb_sdtq_pkg::rsp_word_t  r;
        int         pos;
        logic [sdtq_pkg::TIME_W-1:0] diff;
        bit         found;
        r = '0;
        found = 0;
        if (w.operation == sdtq_pkg::OP_ARM || w.operation == sdtq_pkg::OP_CANCEL)
        begin
            for (int i = 0; i < tbl_id.size(); i++)
                if (!found && tbl_id[i] == w.timer_id)
                begin
                    tbl_id.delete(i);
                    tbl_dl.delete(i);
                    found = 1;
                end
        end
        if (w.operation == sdtq_pkg::OP_ARM)
        begin
            if (tbl_id.size() >= NT)
                r.status = sdtq_pkg::ST_FULL;
            else
            begin
                pos = tbl_id.size();
                for (int i = tbl_id.size() - 1; i >= 0; i--)
                    if (tbl_dl[i] > w.deadline_ms)
                        pos = i;
                tbl_id.insert(pos, w.timer_id);
                tbl_dl.insert(pos, w.deadline_ms);
            end
        end
        else if (w.operation == sdtq_pkg::OP_CANCEL)
        begin
            if (!found)
                r.status = sdtq_pkg::ST_NOT_ARMED;
        end
        else if (w.operation == sdtq_pkg::OP_TICK)
        begin
            if (tbl_id.size() > 0 && tbl_dl[0] <= w.now_ms)
            begin
                r.expired    = 1'b1;
                r.expired_id = tbl_id[0];
                void'(tbl_id.pop_front());
                void'(tbl_dl.pop_front());
            end
        end
        r.wait_ms = sdtq_pkg::WAIT_MAX;
        if (tbl_id.size() > 0)
        begin
            r.any_pending = 1'b1;
            diff = (tbl_dl[0] > w.now_ms) ? tbl_dl[0] - w.now_ms : '0;
            r.wait_ms = (diff > sdtq_pkg::TIME_W'(sdtq_pkg::WAIT_MAX))
                        ? sdtq_pkg::WAIT_MAX : diff[sdtq_pkg::WAIT_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR t=%0t %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // directed table
    typedef struct {
        tb_sdtq_pkg::req_word_t w;
        bit        typed;
        tb_sdtq_pkg::rsp_word_t r;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic tb_sdtq_pkg::req_word_t mk(logic [sdtq_pkg::OP_W-1:0] op,
                                                  logic [sdtq_pkg::ID_W-1:0] id,
                                                  logic [sdtq_pkg::TIME_W-1:0] dl,
                                                  logic [sdtq_pkg::TIME_W-1:0] nw);
        tb_sdtq_pkg::req_word_t w;
        w.operation   = op;
        w.timer_id    = id;
        w.deadline_ms = dl;
        w.now_ms      = nw;
        return w;
    endfunction

    function automatic tb_sdtq_pkg::rsp_word_t rs(logic [sdtq_pkg::STATUS_W-1:0] st,
                                                  logic ex,
                                                  logic [sdtq_pkg::ID_W-1:0] eid,
                                                  logic pend,
                                                  logic [sdtq_pkg::WAIT_W-1:0] wt);
        tb_sdtq_pkg::rsp_word_t r;
        r.status = st; r.expired = ex; r.expired_id = eid;
        r.any_pending = pend; r.wait_ms = wt;
        return r;
    endfunction

    function automatic void add_row(tb_sdtq_pkg::req_word_t w, bit typed,
                                    tb_sdtq_pkg::rsp_word_t r);
        dir_row_t d;
        d.w = w; d.typed = typed; d.r = r;
        dir_rows.push_back(d);
    endfunction

    // send one request word with a random gap; valid drops only for a gap
    task automatic send_word(tb_sdtq_pkg::req_word_t w);
        int gap;
        gap = $urandom_range(3);
        if ($urandom_range(3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= w.operation;
        in_ch.timer_id    <= w.timer_id;
        in_ch.deadline_ms <= w.deadline_ms;
        in_ch.now_ms      <= w.now_ms;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // one accepted request: predict and queue the result
    task automatic push_req(tb_sdtq_pkg::req_word_t w, bit typed,
                            tb_sdtq_pkg::rsp_word_t r);
        tb_sdtq_pkg::rsp_word_t p;
        p = timer_step(w);
        if (typed && p != r)
            report_mismatch("directed row vs model", 64'(p), 64'(r));
        rsp_expected.push_back(typed ? r : p);
        send_word(w);
    endtask

    function automatic tb_sdtq_pkg::req_word_t rand_req(logic [sdtq_pkg::TIME_W-1:0] base);
        tb_sdtq_pkg::req_word_t w;
        int sel;
        sel = $urandom_range(99);
        w.timer_id = sdtq_pkg::ID_W'($urandom_range(15));
        w.now_ms = base + sdtq_pkg::TIME_W'($urandom_range(40));
        w.deadline_ms = base + sdtq_pkg::TIME_W'($urandom_range(60));
        if (sel < 45)
            w.operation = sdtq_pkg::OP_ARM;
        else if (sel < 60)
            w.operation = sdtq_pkg::OP_CANCEL;
        else if (sel < 96)
            w.operation = sdtq_pkg::OP_TICK;
        else
            w.operation = OP_NOP;
        // occasional wide values so every time bit toggles and wait saturates
        if ($urandom_range(15) == 0)
            w.deadline_ms = {16'($urandom_range(16'hffff)), $urandom()};
        if ($urandom_range(15) == 0)
            w.now_ms = {16'($urandom_range(16'hffff)), $urandom()};
        return w;
    endfunction

    // stimulus
    initial
    begin
        logic [sdtq_pkg::TIME_W-1:0] base;
        tb_sdtq_pkg::req_word_t w;
        err_count = 0;
        rx_hold = 0;
        stim_done = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_NOP;
        in_ch.timer_id = '0;
        in_ch.deadline_ms = '0;
        in_ch.now_ms = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        add_row(mk(sdtq_pkg::OP_TICK, 0, 0, T_MAX), 1,
                rs(sdtq_pkg::ST_DONE, 0, 0, 0, sdtq_pkg::WAIT_MAX));
        add_row(mk(sdtq_pkg::OP_CANCEL, 4'hf, 0, 0), 1,
                rs(sdtq_pkg::ST_NOT_ARMED, 0, 0, 0, sdtq_pkg::WAIT_MAX));
        add_row(mk(OP_NOP, 0, 0, 0), 1,
                rs(sdtq_pkg::ST_DONE, 0, 0, 0, sdtq_pkg::WAIT_MAX));
        // extremes of time
        add_row(mk(sdtq_pkg::OP_ARM, 0, T_MAX, 0), 1,
                rs(sdtq_pkg::ST_DONE, 0, 0, 1, sdtq_pkg::WAIT_MAX));
        add_row(mk(sdtq_pkg::OP_ARM, 1, 0, T_MAX), 1,
                rs(sdtq_pkg::ST_DONE, 0, 0, 1, 0));
        add_row(mk(sdtq_pkg::OP_TICK, 0, 0, 0), 1,
                rs(sdtq_pkg::ST_DONE, 1, 1, 1, sdtq_pkg::WAIT_MAX));
        add_row(mk(sdtq_pkg::OP_TICK, 0, 0, T_MAX), 1,
                rs(sdtq_pkg::ST_DONE, 1, 0, 0, sdtq_pkg::WAIT_MAX));
        // fill the table with equal deadlines, then re-arm while full
        for (int i = 0; i < NT; i++)
            add_row(mk(sdtq_pkg::OP_ARM, sdtq_pkg::ID_W'(i), 48'd100, 48'd50), 0, '0);
        add_row(mk(sdtq_pkg::OP_ARM, 4'h5, 48'd10, 48'd50), 0, '0);   // re-arm while full
        add_row(mk(sdtq_pkg::OP_CANCEL, 4'h3, 0, 48'd50), 0, '0);
        add_row(mk(sdtq_pkg::OP_TICK, 0, 0, 48'd10), 0, '0);          // pops re-armed id
        add_row(mk(sdtq_pkg::OP_TICK, 0, 0, 48'd200), 0, '0);
        foreach (dir_rows[i])
            push_req(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // random part; time drifts forward
        base = 48'd1000;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 400)
            begin
                // pause until the block has drained
                in_ch.valid <= 1'b0;
                while (rsp_expected.size() != 0)
                    @(posedge clk);
            end
            if (n == 800)
                rx_hold = 1;
            w = rand_req(base);
            if ($urandom_range(7) == 0)
                base = base + sdtq_pkg::TIME_W'($urandom_range(20));
            push_req(w, 0, '0);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge clk);
                rx_hold = 0;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        tb_sdtq_pkg::rsp_word_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (rsp_expected.size() == 0)
                report_mismatch("unexpected result", 64'(out_ch.status), 64'hx);
            else
            begin
                e = rsp_expected.pop_front();
                if (out_ch.status !== e.status)
                    report_mismatch("status", 64'(out_ch.status), 64'(e.status));
                if (out_ch.expired !== e.expired)
                    report_mismatch("expired", 64'(out_ch.expired), 64'(e.expired));
                if (out_ch.expired_id !== e.expired_id)
                    report_mismatch("expired_id", 64'(out_ch.expired_id),
                                    64'(e.expired_id));
                if (out_ch.any_pending !== e.any_pending)
                    report_mismatch("any_pending", 64'(out_ch.any_pending),
                                    64'(e.any_pending));
                if (out_ch.wait_ms !== e.wait_ms)
                    report_mismatch("wait_ms", 64'(out_ch.wait_ms), 64'(e.wait_ms));
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("sorted_deadline_timer_queue: match");
        else
            $display("sorted_deadline_timer_queue: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("sorted_deadline_timer_queue: mismatch");
        $finish;
    end

endmodule
